### design/rgbc5_pkg.sv
// Shared constants, types and register codes of the RGB 5x5 convolution core.
`timescale 1ns / 1ps

package rgbc5_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int COEF_BITS  = 12;
    localparam int FRAC_BITS  = 10;

    localparam int KSIZE      = 5;
    localparam int HALF_K     = KSIZE / 2;
    localparam int LB_ROWS    = KSIZE - 1;
    localparam int PIX_BITS   = 8;
    localparam int ROW_BITS   = KSIZE * COEF_BITS;
    localparam int CFG_BITS   = 60;
    localparam int CFG_IDX_W  = 3;
    localparam int GEOM_BITS  = 11;

    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int OROW_W     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int VROW_W     = $clog2(MAX_HEIGHT + KSIZE);
    localparam int WDIM_W     = $clog2(MAX_WIDTH + 1);
    localparam int HDIM_W     = $clog2(MAX_HEIGHT + 1);

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] REG_KROW0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KROW4  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd6;

    localparam logic MODE_PIXEL = 1'b0;

    typedef struct packed {
        logic [PIX_BITS-1:0] blue;
        logic [PIX_BITS-1:0] green;
        logic [PIX_BITS-1:0] red;
    } pix_t;

    typedef pix_t [LB_ROWS-1:0] lb_entry_t;

    typedef logic [KSIZE-1:0][KSIZE-1:0][COEF_BITS-1:0] kernel_t;

    typedef struct packed {
        logic [KSIZE-1:0] row_en;
        logic [KSIZE-1:0] col_en;
    } tap_mask_t;

    typedef struct packed {
        logic last;
        pix_t pix;
    } out_item_t;

endpackage

### design/rgbc5_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module rgbc5_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### design/rgbc5_lane.sv
// One color lane: 25 masked products, row sums, final sum, scaling and clamping.
`timescale 1ns / 1ps

module rgbc5_lane (
    input  logic                          aclk,
    input  logic [rgbc5_pkg::PIX_BITS-1:0] px [rgbc5_pkg::KSIZE][rgbc5_pkg::KSIZE],
    input  rgbc5_pkg::kernel_t            kern,
    input  rgbc5_pkg::tap_mask_t          tap_mask,
    output logic [rgbc5_pkg::PIX_BITS-1:0] result_reg
);
    import rgbc5_pkg::*;

    localparam int PROD_W = PIX_BITS + 1 + COEF_BITS;
    localparam int RSUM_W = PROD_W + 3;
    localparam int ACC_W  = PROD_W + 5;
    localparam logic signed [ACC_W-1:0] PIX_MAX = ACC_W'(255);

    logic signed [PROD_W-1:0] prod_reg [KSIZE][KSIZE];
    logic signed [RSUM_W-1:0] rsum_reg [KSIZE];
    logic signed [RSUM_W-1:0] rsum_next [KSIZE];
    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  scaled;
    logic [PIX_BITS-1:0]      result_next;

    // Products; taps outside the image are forced to zero.
    always_ff @(posedge aclk) begin
        for (int i = 0; i < KSIZE; i++) begin
            for (int j = 0; j < KSIZE; j++) begin
                if (tap_mask.row_en[i] && tap_mask.col_en[j]) begin
                    prod_reg[i][j] <= $signed({1'b0, px[i][j]}) * $signed(kern[i][j]);
                end else begin
                    prod_reg[i][j] <= '0;
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < KSIZE; i++) begin
            rsum_next[i] = '0;
            for (int j = 0; j < KSIZE; j++) begin
                rsum_next[i] = rsum_next[i] + RSUM_W'(prod_reg[i][j]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < KSIZE; i++) begin
            rsum_reg[i] <= rsum_next[i];
        end
    end

    always_comb begin
        acc = '0;
        for (int i = 0; i < KSIZE; i++) begin
            acc = acc + ACC_W'(rsum_reg[i]);
        end
        scaled = acc >>> FRAC_BITS;
        if (acc <= 0) begin
            result_next = '0;
        end else if (scaled > PIX_MAX) begin
            result_next = '1;
        end else begin
            result_next = scaled[PIX_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        result_reg <= result_next;
    end

endmodule

### design/rgbc5_merge.sv
// Merging stage: joins the three lane results and queues them for the output stream.
`timescale 1ns / 1ps

module rgbc5_merge (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          push,
    input  logic                          push_last,
    input  logic [rgbc5_pkg::PIX_BITS-1:0] red,
    input  logic [rgbc5_pkg::PIX_BITS-1:0] green,
    input  logic [rgbc5_pkg::PIX_BITS-1:0] blue,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [23:0]                   m_tdata,   // red [7:0], green [15:8], blue [23:16]
    output logic                          m_tlast
);
    import rgbc5_pkg::*;

    out_item_t               fifo_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wptr_reg;
    logic [FIFO_PTR_W-1:0]   rptr_reg;
    logic [FIFO_CNT_W-1:0]   count_reg;
    logic                    pop;
    out_item_t               head;

    assign head     = fifo_reg[rptr_reg];
    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = head.pix;
    assign m_tlast  = head.last;
    assign pop      = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wptr_reg] <= '{last: push_last,
                                    pix: '{blue: blue, green: green, red: red}};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop) begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            count_reg <= count_reg + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == FIFO_CNT_W'(FIFO_DEPTH)) |-> !push || pop)
        else $error("result queue overflow");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg <= FIFO_CNT_W'(FIFO_DEPTH)))
        else $error("result queue count out of range");
    a_push_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop && count_reg < FIFO_CNT_W'(FIFO_DEPTH)) |=> count_reg != '0)
        else $error("pushed result not counted");
`endif

endmodule

### design/rgb_conv5x5_zero_pad_core.sv
// Top level of the RGB 5x5 zero-padded convolution core.
`timescale 1ns / 1ps

// RGB 5x5 convolution with zero padding. Pixels stream in raster order, one per
// transfer (tuser = 0), and one signed Q2.10 5x5 kernel is applied to each color
// channel; each result is floor(sum / 1024) clamped to 0..255. Output pixel k
// leaves with input pixel k + 2W + 2, so after the last pixel of a frame the
// source sends flush transfers (tuser = 1), one per owed output; m_tlast marks
// the last output of the frame. The core accepts one transfer per clock while
// s_tready is high: four line buffers in one wide RAM (one read and one write
// port) deliver a five-pixel column each cycle, a 5x5 window register feeds
// three channel lanes working in parallel, and a small result queue absorbs
// output stalls. An emitted result passes the lane registers and the result
// queue. For frames of fewer than 2W + 2 pixels, the core holds s_tready low
// at frame end while it steps its window to the first owed output.
// Writing image_width or image_height restarts the frame; configure only while
// idle. Coefficient rows are written as five 12-bit fields, column j at bit 12j.

module rgb_conv5x5_zero_pad_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [23:0]                    s_tdata,    // red_in [7:0], green_in [15:8], blue_in [23:16]
    input  logic                           s_tuser,    // mode
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [23:0]                    m_tdata,    // red_out [7:0], green_out [15:8], blue_out [23:16]
    output logic                           m_tlast,    // frame_end
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rgbc5_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rgbc5_pkg::CFG_BITS-1:0] cfg_data
);
    import rgbc5_pkg::*;

    localparam logic [ROW_BITS-1:0] KROW2_RESET =
        ROW_BITS'(64'(1) << (FRAC_BITS + 2 * COEF_BITS));

    // Configuration registers; geometry is stored already limited to range.
    logic [ROW_BITS-1:0] krow_reg [KSIZE];
    logic [WDIM_W-1:0]   width_reg;
    logic [HDIM_W-1:0]   height_reg;

    // Position of the next window step and of the next owed output.
    logic [COL_W-1:0]    vx_reg, vx_next;
    logic [VROW_W-1:0]   vy_reg, vy_next;
    logic [COL_W-1:0]    ox_reg, ox_next;
    logic [OROW_W-1:0]   oy_reg, oy_next;
    logic [FIFO_CNT_W-1:0] pending_reg;

    logic cfg_we, restart;
    logic [2:0] lag_row;
    logic [1:0] lag_col;
    logic started, in_done, adv_int, accept, is_pix, is_flush, step, emit, out_last;
    logic col_wrap;

    pix_t       pix_in;
    pix_t       column [KSIZE];
    lb_entry_t  lb_rdata, lb_entry, lb_wdata, byp_data_reg;
    logic       byp_valid_reg;
    pix_t       window_reg [KSIZE][KSIZE];

    tap_mask_t  mask_next, mask_s0_reg;
    logic       vld_s0_reg, vld_s1_reg, vld_s2_reg, vld_s3_reg;
    logic       last_s0_reg, last_s1_reg, last_s2_reg, last_s3_reg;

    kernel_t    kern;
    logic [PIX_BITS-1:0] px_r [KSIZE][KSIZE];
    logic [PIX_BITS-1:0] px_g [KSIZE][KSIZE];
    logic [PIX_BITS-1:0] px_b [KSIZE][KSIZE];
    logic [PIX_BITS-1:0] res_r, res_g, res_b;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign restart   = cfg_we && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);

    // The first output is owed once the step position reaches 2W + 2.
    always_comb begin
        if (width_reg == WDIM_W'(1)) begin
            lag_row = 3'd4;
            lag_col = 2'd0;
        end else if (width_reg == WDIM_W'(2)) begin
            lag_row = 3'd3;
            lag_col = 2'd0;
        end else begin
            lag_row = 3'd2;
            lag_col = 2'd2;
        end
    end

    always_comb begin
        started  = (32'(vy_reg) > 32'(lag_row))
                || (32'(vy_reg) == 32'(lag_row) && 32'(vx_reg) >= 32'(lag_col));
        in_done  = 32'(vy_reg) >= 32'(height_reg);
        // Small frames: walk the window forward on our own until outputs are owed.
        adv_int  = in_done && !started;
        s_tready = !adv_int && (pending_reg < FIFO_CNT_W'(FIFO_DEPTH));
        accept   = s_tvalid && s_tready;
        is_pix   = accept && (s_tuser == MODE_PIXEL) && !in_done;
        // After frame end every transfer acts as a flush; a pixel is dropped.
        is_flush = accept && in_done;
        step     = is_pix || is_flush || adv_int;
        emit     = (is_pix && started) || is_flush;
        out_last = (32'(oy_reg) + 1 == 32'(height_reg))
                && (32'(ox_reg) + 1 == 32'(width_reg));
        col_wrap = (32'(vx_reg) + 1 == 32'(width_reg));
    end

    always_comb begin
        vx_next = vx_reg;
        vy_next = vy_reg;
        ox_next = ox_reg;
        oy_next = oy_reg;
        if (step) begin
            if (col_wrap) begin
                vx_next = '0;
                vy_next = vy_reg + 1'b1;
            end else begin
                vx_next = vx_reg + 1'b1;
            end
        end
        if (emit) begin
            if (32'(ox_reg) + 1 == 32'(width_reg)) begin
                ox_next = '0;
                oy_next = oy_reg + 1'b1;
            end else begin
                ox_next = ox_reg + 1'b1;
            end
        end
        if ((emit && out_last) || restart) begin
            vx_next = '0;
            vy_next = '0;
            ox_next = '0;
            oy_next = '0;
        end
    end

    // Line buffers: entry x holds column x of the four previous rows.
    rgbc5_ram #(
        .WIDTH ($bits(lb_entry_t)),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (step),
        .waddr (vx_reg),
        .wdata (lb_wdata),
        .raddr (vx_next),
        .rdata (lb_rdata)
    );

    always_comb begin
        pix_in   = is_pix ? pix_t'(s_tdata) : '0;
        lb_entry = byp_valid_reg ? byp_data_reg : lb_rdata;
        lb_wdata[0] = pix_in;
        for (int k = 1; k < LB_ROWS; k++) begin
            lb_wdata[k] = lb_entry[k-1];
        end
        // Column of five rows, oldest row first.
        column[KSIZE-1] = pix_in;
        for (int k = 0; k < LB_ROWS; k++) begin
            column[LB_ROWS-1-k] = lb_entry[k];
        end
    end

    // Forward a write to the address read in the same cycle (one-pixel lines).
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byp_valid_reg <= 1'b0;
        end else begin
            byp_valid_reg <= step && (vx_next == vx_reg);
        end
        byp_data_reg <= lb_wdata;
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            for (int j = 0; j < KSIZE - 1; j++) begin
                window_reg[j] <= window_reg[j+1];
            end
            window_reg[KSIZE-1] <= column;
        end
    end

    // Taps whose row or column lies outside the image count as zero.
    always_comb begin
        for (int k = 0; k < KSIZE; k++) begin
            mask_next.row_en[k] = (32'(oy_reg) + k >= HALF_K)
                               && (32'(oy_reg) + k < 32'(height_reg) + HALF_K);
            mask_next.col_en[k] = (32'(ox_reg) + k >= HALF_K)
                               && (32'(ox_reg) + k < 32'(width_reg) + HALF_K);
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            mask_s0_reg <= mask_next;
            last_s0_reg <= out_last;
        end
        last_s1_reg <= last_s0_reg;
        last_s2_reg <= last_s1_reg;
        last_s3_reg <= last_s2_reg;
    end

    always_comb begin
        for (int i = 0; i < KSIZE; i++) begin
            for (int j = 0; j < KSIZE; j++) begin
                kern[i][j]  = krow_reg[i][COEF_BITS*j +: COEF_BITS];
                px_r[i][j]  = window_reg[j][i].red;
                px_g[i][j]  = window_reg[j][i].green;
                px_b[i][j]  = window_reg[j][i].blue;
            end
        end
    end

    rgbc5_lane u_lane_r (
        .aclk (aclk), .px (px_r), .kern (kern), .tap_mask (mask_s0_reg), .result_reg (res_r)
    );
    rgbc5_lane u_lane_g (
        .aclk (aclk), .px (px_g), .kern (kern), .tap_mask (mask_s0_reg), .result_reg (res_g)
    );
    rgbc5_lane u_lane_b (
        .aclk (aclk), .px (px_b), .kern (kern), .tap_mask (mask_s0_reg), .result_reg (res_b)
    );

    rgbc5_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (vld_s3_reg),
        .push_last (last_s3_reg),
        .red       (res_r),
        .green     (res_g),
        .blue      (res_b),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // Control registers, configuration and credit count for the result queue.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < KSIZE; r++) begin
                krow_reg[r] <= '0;
            end
            krow_reg[HALF_K] <= KROW2_RESET;
            width_reg   <= WDIM_W'(MAX_WIDTH);
            height_reg  <= HDIM_W'(MAX_HEIGHT);
            vx_reg      <= '0;
            vy_reg      <= '0;
            ox_reg      <= '0;
            oy_reg      <= '0;
            pending_reg <= '0;
            vld_s0_reg  <= 1'b0;
            vld_s1_reg  <= 1'b0;
            vld_s2_reg  <= 1'b0;
            vld_s3_reg  <= 1'b0;
        end else begin
            vx_reg <= vx_next;
            vy_reg <= vy_next;
            ox_reg <= ox_next;
            oy_reg <= oy_next;
            vld_s0_reg <= emit;
            vld_s1_reg <= vld_s0_reg;
            vld_s2_reg <= vld_s1_reg;
            vld_s3_reg <= vld_s2_reg;
            pending_reg <= pending_reg + FIFO_CNT_W'(emit)
                         - FIFO_CNT_W'(m_tvalid && m_tready);
            if (cfg_we) begin
                if (cfg_index <= REG_KROW4) begin
                    krow_reg[cfg_index - REG_KROW0] <= cfg_data[ROW_BITS-1:0];
                end else if (cfg_index == REG_WIDTH) begin
                    if (cfg_data[GEOM_BITS-1:0] == '0) begin
                        width_reg <= WDIM_W'(1);
                    end else if (32'(cfg_data[GEOM_BITS-1:0]) > MAX_WIDTH) begin
                        width_reg <= WDIM_W'(MAX_WIDTH);
                    end else begin
                        width_reg <= WDIM_W'(cfg_data[GEOM_BITS-1:0]);
                    end
                end else if (cfg_index == REG_HEIGHT) begin
                    if (cfg_data[GEOM_BITS-1:0] == '0) begin
                        height_reg <= HDIM_W'(1);
                    end else if (32'(cfg_data[GEOM_BITS-1:0]) > MAX_HEIGHT) begin
                        height_reg <= HDIM_W'(MAX_HEIGHT);
                    end else begin
                        height_reg <= HDIM_W'(cfg_data[GEOM_BITS-1:0]);
                    end
                end
            end
        end
    end

`ifndef SYNTH
    a_credit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("more results owed than the queue can hold");
    a_walk_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        adv_int |-> !s_tready)
        else $error("input taken while the window walks forward on its own");
    a_frame_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && out_last) |=> (vx_reg == '0 && vy_reg == '0 && ox_reg == '0 && oy_reg == '0))
        else $error("counters not cleared after the last output of a frame");
    a_emit_reaches_queue: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> ##4 vld_s3_reg)
        else $error("emitted result lost in the lane pipeline");
`endif

endmodule
